@@ src/lcwsd_pkg.sv @@
// Shared widths, codes, reset values and payload types for the stability detector.
package lcwsd_pkg;

    localparam int RAW_W     = 24;
    localparam int OFFSET_W  = 25;
    localparam int GAIN_W    = 32;
    localparam int NEED_W    = 8;
    localparam int DIFF_W    = 26;
    localparam int POS_W     = 25;
    localparam int PROD_W    = POS_W + GAIN_W;
    localparam int FRAC_W    = 32;
    localparam int ROUND_W   = PROD_W - FRAC_W + 1;
    localparam int WEIGHT_W  = 16;
    localparam int STATUS_W  = 2;
    localparam int RUN_W     = 8;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 32;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [STATUS_W-1:0] STATUS_VALID     = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_SATURATED = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_NOT_READY = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_ZERO_OFFSET   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_POUNDS_PER_CT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_STABLE_NEEDED = 2'd2;

    localparam logic signed [OFFSET_W-1:0] ZERO_OFFSET_RST = 25'sd1114690;
    localparam logic [GAIN_W-1:0]          GAIN_RST        = 32'd468385;
    localparam logic [NEED_W-1:0]          NEED_RST        = 8'd10;

    localparam logic [RAW_W-1:0] RAIL_HIGH = 24'h7FFFFF;
    localparam logic [RAW_W-1:0] RAIL_LOW  = 24'h800000;

    typedef struct packed {
        logic signed [OFFSET_W-1:0] zero_offset;
        logic [GAIN_W-1:0]          gain;
    } t_front_cfg;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [WEIGHT_W-1:0] weight;
    } t_work;

endpackage

@@ src/lcwsd_in_if.sv @@
// Input channel: ready flag and raw converter reading with valid/ready handshake.
interface lcwsd_in_if;
    import lcwsd_pkg::*;

    logic                    valid;
    logic                    ready;
    logic                    sensor_ready;
    logic signed [RAW_W-1:0] raw_counts;

    modport source(output valid, output sensor_ready, output raw_counts, input ready);
    modport sink(input valid, input sensor_ready, input raw_counts, output ready);
endinterface

@@ src/lcwsd_out_if.sv @@
// Result channel: status, weight, run length and sleep request with valid/ready handshake.
interface lcwsd_out_if;
    import lcwsd_pkg::*;

    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status_code;
    logic [WEIGHT_W-1:0] weight_pounds;
    logic [RUN_W-1:0]    run_length;
    logic                sleep_request;

    modport source(output valid, output status_code, output weight_pounds,
                   output run_length, output sleep_request, input ready);
    modport sink(input valid, input status_code, input weight_pounds,
                 input run_length, input sleep_request, output ready);
endinterface

@@ src/load_cell_weight_stability_detector.sv @@
// Top level of the load-cell weight stability detector.
// Each accepted beat carries a ready flag and one averaged 24-bit reading and produces
// exactly one result beat: status (valid, saturated, not ready), the weight in whole
// pounds ((raw - zero_offset) * pounds_per_count in Q0.32, clamped at zero, rounded
// half-up, saturated at 65535), the run of consecutive equal weights and a sleep
// request once that run reaches stable_needed. The block takes one beat per clock
// when the result side keeps up. Each beat passes in order through offset subtract,
// 25x32 multiply, round and saturate, the queue and the result register.
// The 25x32 multiply stage sets the clock rate. A two-entry queue separates the
// scaling pipeline from the tracking logic so either side can stall independently.
// Write configuration only while the block is idle; an index past the last register
// is ignored. COUNT_BITS sets the width of the equal-run counter.
module load_cell_weight_stability_detector #(
    parameter int COUNT_BITS = 8
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    lcwsd_in_if.sink                          i_sample,
    lcwsd_out_if.source                       o_result,
    input  logic                              i_cfg_we,
    input  logic [lcwsd_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [lcwsd_pkg::CFG_DATA_W-1:0]  i_cfg_data
);
    import lcwsd_pkg::*;

    // Calibration and threshold registers.
    logic signed [OFFSET_W-1:0] r_zero_offset;
    logic [GAIN_W-1:0]          r_gain;
    logic [NEED_W-1:0]          r_stable_needed;

    t_front_cfg front_cfg;
    t_work      front_work, queue_work;
    logic       front_valid, front_ready;
    logic       queue_valid, queue_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_zero_offset   <= ZERO_OFFSET_RST;
            r_gain          <= GAIN_RST;
            r_stable_needed <= NEED_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_ZERO_OFFSET: begin
                    r_zero_offset <= i_cfg_data[OFFSET_W-1:0];
                end
                CFG_POUNDS_PER_CT: begin
                    r_gain <= i_cfg_data[GAIN_W-1:0];
                end
                CFG_STABLE_NEEDED: begin
                    r_stable_needed <= i_cfg_data[NEED_W-1:0];
                end
                default: begin
                    // Drop writes to unused indexes.
                end
            endcase
        end
    end

    assign front_cfg.zero_offset = r_zero_offset;
    assign front_cfg.gain        = r_gain;

    // Front: classify, subtract offset, scale, round and saturate.
    lcwsd_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_sample     (i_sample),
        .i_cfg        (front_cfg),
        .o_work_valid (front_valid),
        .o_work       (front_work),
        .i_work_ready (front_ready)
    );

    // Hold scaled beats until the tracking side can take them.
    lcwsd_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (front_valid),
        .o_push_ready (front_ready),
        .i_push_data  (front_work),
        .o_pop_valid  (queue_valid),
        .i_pop_ready  (queue_ready),
        .o_pop_data   (queue_work)
    );

    // Back: equal-weight tracking, sleep request and the result register.
    lcwsd_back #(
        .COUNT_BITS (COUNT_BITS)
    ) u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_work_valid    (queue_valid),
        .o_work_ready    (queue_ready),
        .i_work          (queue_work),
        .i_stable_needed (r_stable_needed),
        .o_result        (o_result)
    );

endmodule

@@ src/lcwsd_front.sv @@
// Front pipeline: classify the reading, subtract the offset, scale, round and saturate.
module lcwsd_front (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    lcwsd_in_if.sink               i_sample,
    input  lcwsd_pkg::t_front_cfg  i_cfg,
    output logic                   o_work_valid,
    output lcwsd_pkg::t_work       o_work,
    input  logic                   i_work_ready
);
    import lcwsd_pkg::*;

    logic                r_v1, r_v2, r_v3;
    logic                s1_rdy, s2_rdy, s3_rdy;
    logic [STATUS_W-1:0] r_status1, r_status2, r_status3;
    logic [POS_W-1:0]    r_pos_diff;
    logic [PROD_W-1:0]   r_prod;
    logic [WEIGHT_W-1:0] r_weight;

    logic [STATUS_W-1:0]     n_status;
    logic signed [DIFF_W-1:0] w_diff;
    logic [POS_W-1:0]        n_pos_diff;
    logic [ROUND_W-1:0]      w_round;
    logic [WEIGHT_W-1:0]     n_weight;

    // Ready ripples back from the queue; a stage loads whenever it is free or draining.
    assign s3_rdy = !r_v3 || i_work_ready;
    assign s2_rdy = !r_v2 || s3_rdy;
    assign s1_rdy = !r_v1 || s2_rdy;
    assign i_sample.ready = s1_rdy;

    always_comb begin
        w_diff = DIFF_W'(i_sample.raw_counts) - DIFF_W'(i_cfg.zero_offset);
        if (!i_sample.sensor_ready) begin
            n_status = STATUS_NOT_READY;
        end else if (i_sample.raw_counts == RAIL_HIGH || i_sample.raw_counts == RAIL_LOW) begin
            n_status = STATUS_SATURATED;
        end else begin
            n_status = STATUS_VALID;
        end
        // Drop non-positive differences and invalid readings to zero weight.
        if (n_status == STATUS_VALID && w_diff > 0) begin
            n_pos_diff = w_diff[POS_W-1:0];
        end else begin
            n_pos_diff = '0;
        end
    end

    always_comb begin
        w_round = ROUND_W'(r_prod[PROD_W-1:FRAC_W]) + ROUND_W'(r_prod[FRAC_W-1]);
        if (|w_round[ROUND_W-1:WEIGHT_W]) begin
            n_weight = '1;
        end else begin
            n_weight = w_round[WEIGHT_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (s1_rdy) begin
                r_v1 <= i_sample.valid;
            end
            if (s2_rdy) begin
                r_v2 <= r_v1;
            end
            if (s3_rdy) begin
                r_v3 <= r_v2;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_rdy) begin
            r_status1  <= n_status;
            r_pos_diff <= n_pos_diff;
        end
        if (s2_rdy) begin
            r_status2 <= r_status1;
            r_prod    <= PROD_W'(r_pos_diff) * PROD_W'(i_cfg.gain);
        end
        if (s3_rdy) begin
            r_status3 <= r_status2;
            r_weight  <= n_weight;
        end
    end

    assign o_work_valid  = r_v3;
    assign o_work.status = r_status3;
    assign o_work.weight = r_weight;

endmodule

@@ src/lcwsd_queue.sv @@
// Short FIFO between the scaling front and the tracking back.
module lcwsd_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push_valid,
    output logic             o_push_ready,
    input  lcwsd_pkg::t_work i_push_data,
    output logic             o_pop_valid,
    input  logic             i_pop_ready,
    output lcwsd_pkg::t_work o_pop_data
);
    import lcwsd_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    t_work             r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0]  r_wr_ptr, r_rd_ptr;
    logic [CNT_W-1:0]  r_count;
    logic              push, pop;

    assign o_push_ready = r_count != CNT_W'(QUEUE_DEPTH);
    assign o_pop_valid  = r_count != '0;
    assign o_pop_data   = r_mem[r_rd_ptr];
    assign push = i_push_valid && o_push_ready;
    assign pop  = o_pop_valid && i_pop_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (push && !pop) begin
                r_count <= r_count + 1'b1;
            end else if (pop && !push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= i_push_data;
        end
    end

endmodule

@@ src/lcwsd_back.sv @@
// Back end: track equal weights, raise sleep requests, hold the result register.
module lcwsd_back #(
    parameter int COUNT_BITS = 8
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_work_valid,
    output logic                        o_work_ready,
    input  lcwsd_pkg::t_work            i_work,
    input  logic [lcwsd_pkg::NEED_W-1:0] i_stable_needed,
    lcwsd_out_if.source                 o_result
);
    import lcwsd_pkg::*;

    localparam int CMP_W = (COUNT_BITS > NEED_W) ? COUNT_BITS : NEED_W;
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

    logic                  r_ref_valid;
    logic [WEIGHT_W-1:0]   r_ref_weight;
    logic [COUNT_BITS-1:0] r_count;

    logic                  r_out_valid;
    logic [STATUS_W-1:0]   r_out_status;
    logic [WEIGHT_W-1:0]   r_out_weight;
    logic [RUN_W-1:0]      r_out_run;
    logic                  r_out_sleep;

    logic                  pop;
    logic                  n_ref_valid;
    logic [WEIGHT_W-1:0]   n_ref_weight;
    logic [COUNT_BITS-1:0] n_count;
    logic                  n_sleep;

    assign o_work_ready = !r_out_valid || o_result.ready;
    assign pop = i_work_valid && o_work_ready;

    always_comb begin
        n_ref_valid  = r_ref_valid;
        n_ref_weight = r_ref_weight;
        n_count      = r_count;
        if (i_work.status == STATUS_VALID) begin
            if (!r_ref_valid || i_work.weight != r_ref_weight) begin
                n_ref_weight = i_work.weight;
                n_count      = COUNT_BITS'(1);
                n_ref_valid  = 1'b1;
            end else if (r_count != COUNT_MAX) begin
                n_count = r_count + 1'b1;
            end
        end else begin
            n_ref_valid = 1'b0;
            n_count     = '0;
        end
        n_sleep = CMP_W'(n_count) >= CMP_W'(i_stable_needed);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ref_valid  <= 1'b0;
            r_ref_weight <= '0;
            r_count      <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            if (pop) begin
                r_ref_weight <= n_ref_weight;
                // Clear the tracking once sleep is requested; keep the reference weight.
                r_ref_valid  <= n_ref_valid && !n_sleep;
                r_count      <= n_sleep ? '0 : n_count;
                r_out_valid  <= 1'b1;
            end else if (o_result.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (pop) begin
            r_out_status <= i_work.status;
            r_out_weight <= i_work.weight;
            r_out_run    <= RUN_W'(n_count);
            r_out_sleep  <= n_sleep;
        end
    end

    assign o_result.valid         = r_out_valid;
    assign o_result.status_code   = r_out_status;
    assign o_result.weight_pounds = r_out_weight;
    assign o_result.run_length    = r_out_run;
    assign o_result.sleep_request = r_out_sleep;

endmodule

@@ src/lcwsd_checker.sv @@
// Port-level checker for the stability detector and its bind to the top level.
module lcwsd_port_checks (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              i_out_valid,
    input logic                              i_out_ready,
    input logic [lcwsd_pkg::STATUS_W-1:0]    i_status,
    input logic [lcwsd_pkg::WEIGHT_W-1:0]    i_weight,
    input logic [lcwsd_pkg::RUN_W-1:0]       i_run,
    input logic                              i_sleep
);
    import lcwsd_pkg::*;

    a_stall_holds_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result beat dropped while stalled");

    a_stall_holds_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=>
            $stable(i_status) && $stable(i_weight) && $stable(i_run) && $stable(i_sleep))
        else $error("result beat changed while stalled");

    a_invalid_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_status != STATUS_VALID |-> i_weight == '0 && i_run == '0)
        else $error("non-valid status with weight or run length");

    a_valid_counts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_status == STATUS_VALID |-> i_run != '0)
        else $error("valid weight with empty run length");

endmodule

bind load_cell_weight_stability_detector lcwsd_port_checks u_lcwsd_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_result.valid),
    .i_out_ready (o_result.ready),
    .i_status    (o_result.status_code),
    .i_weight    (o_result.weight_pounds),
    .i_run       (o_result.run_length),
    .i_sleep     (o_result.sleep_request)
);

@@ tb/lcwsd_checker.sv @@
// Checker: watches the sample, result and register channels, predicts and compares results.
module lcwsd_checker
    import lcwsd_pkg::*;
#(
    parameter int COUNT_BITS = 8
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    lcwsd_in_if                   smp_bus,
    lcwsd_out_if                  res_bus,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output int                    o_fail_count,
    output int                    o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [WEIGHT_W-1:0] weight;
        logic [RUN_W-1:0]    run_length;
        logic                sleep_request;
    } t_weighing;

    // register copies
    logic signed [OFFSET_W-1:0] cfg_offset;
    logic [GAIN_W-1:0]          cfg_gain;
    logic [NEED_W-1:0]          cfg_need;

    // stability tracking
    logic [WEIGHT_W-1:0]   anchor_weight;
    logic                  anchor_held;
    logic [COUNT_BITS-1:0] equal_run;

    t_weighing weighings_due[$];
    int        fails;
    int        results_seen;

    assign o_fail_count = fails;
    assign o_pending    = weighings_due.size();

    task automatic flag_mismatch(input string note);
        $display("ERROR at %0t ns: %s", $time, note);
        fails++;
    endtask

    // Scale one reading to pounds and advance the equal-weight tracking.
    function automatic t_weighing weigh_and_track(input logic rdy,
                                                  input logic signed [RAW_W-1:0] raw);
        t_weighing              w;
        logic signed [DIFF_W-1:0] diff;
        logic [63:0]            prod;
        logic [63:0]            pounds;
        w = '0;
        if (!rdy) begin
            w.status = STATUS_NOT_READY;
        end else if (raw == RAIL_HIGH || raw == RAIL_LOW) begin
            w.status = STATUS_SATURATED;
        end else begin
            w.status = STATUS_VALID;
            diff = raw - cfg_offset;
            if (diff > 0) begin
                prod   = 64'(diff[POS_W-1:0]) * 64'(cfg_gain);
                pounds = (prod + 64'h8000_0000) >> FRAC_W;
                w.weight = (pounds > 64'd65535) ? 16'hFFFF : pounds[WEIGHT_W-1:0];
            end
        end

        if (w.status == STATUS_VALID) begin
            if (!anchor_held || w.weight != anchor_weight) begin
                anchor_weight = w.weight;
                equal_run     = COUNT_BITS'(1);
                anchor_held   = 1'b1;
            end else if (equal_run < COUNT_MAX) begin
                equal_run++;
            end
        end else begin
            anchor_held = 1'b0;
            equal_run   = '0;
        end

        w.sleep_request = (equal_run >= cfg_need);
        w.run_length    = RUN_W'(equal_run);
        if (w.sleep_request) begin
            equal_run   = '0;
            anchor_held = 1'b0;
        end
        return w;
    endfunction

    always @(posedge i_clk) begin : watch
        t_weighing seen;
        t_weighing want;
        if (!i_rst_n) begin
            cfg_offset    = ZERO_OFFSET_RST;
            cfg_gain      = GAIN_RST;
            cfg_need      = NEED_RST;
            anchor_weight = '0;
            anchor_held   = 1'b0;
            equal_run     = '0;
            weighings_due.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_ZERO_OFFSET:   cfg_offset = i_cfg_data[OFFSET_W-1:0];
                    CFG_POUNDS_PER_CT: cfg_gain   = i_cfg_data[GAIN_W-1:0];
                    CFG_STABLE_NEEDED: cfg_need   = i_cfg_data[NEED_W-1:0];
                    default: ;
                endcase
            end
            // retire a result before queuing a new one: latency keeps them apart
            if (res_bus.valid && res_bus.ready) begin
                seen = '{res_bus.status_code, res_bus.weight_pounds,
                         res_bus.run_length, res_bus.sleep_request};
                if (weighings_due.size() == 0) begin
                    flag_mismatch($sformatf("result %0d arrived with none expected",
                                            results_seen));
                end else begin
                    want = weighings_due.pop_front();
                    if (seen.status != want.status)
                        flag_mismatch($sformatf("result %0d status exp %0d got %0d",
                                                results_seen, want.status, seen.status));
                    if (seen.weight != want.weight)
                        flag_mismatch($sformatf("result %0d weight exp %0d got %0d",
                                                results_seen, want.weight, seen.weight));
                    if (seen.run_length != want.run_length)
                        flag_mismatch($sformatf("result %0d run_length exp %0d got %0d",
                                                results_seen, want.run_length,
                                                seen.run_length));
                    if (seen.sleep_request != want.sleep_request)
                        flag_mismatch($sformatf("result %0d sleep_request exp %0d got %0d",
                                                results_seen, want.sleep_request,
                                                seen.sleep_request));
                end
                results_seen++;
            end
            if (smp_bus.valid && smp_bus.ready) begin
                weighings_due.push_back(weigh_and_track(smp_bus.sensor_ready,
                                                        smp_bus.raw_counts));
            end
        end
    end

    initial begin
        fails        = 0;
        results_seen = 0;
    end

endmodule

@@ tb/tb_top.sv @@
// Testbench top: clock, reset, register writes, sample stimulus, result stalls and verdict.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import lcwsd_pkg::*;

    localparam int RUN_COUNT_BITS = 8;
    // index past the last register; writes there must be dropped
    localparam logic [CFG_IDX_W-1:0] CFG_NO_REG = 2'd3;
    localparam int END_HOLD = 10;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_idx;
    logic [CFG_DATA_W-1:0] cfg_data;
    int                    fail_count;
    int                    n_pending;

    // Suppress idling on both sides while set (final phase).
    logic                  calm;

    // Mirrors of the current settings, used only to shape stimulus.
    logic signed [OFFSET_W-1:0] set_offset;
    logic [NEED_W-1:0]          set_need;

    lcwsd_in_if  smp_bus();
    lcwsd_out_if res_bus();

    always #10 i_clk = ~i_clk;

    load_cell_weight_stability_detector #(
        .COUNT_BITS(RUN_COUNT_BITS)
    ) dut (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_sample  (smp_bus),
        .o_result  (res_bus),
        .i_cfg_we  (cfg_we),
        .i_cfg_idx (cfg_idx),
        .i_cfg_data(cfg_data)
    );

    lcwsd_checker #(
        .COUNT_BITS(RUN_COUNT_BITS)
    ) chk (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .smp_bus     (smp_bus),
        .res_bus     (res_bus),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_data  (cfg_data),
        .o_fail_count(fail_count),
        .o_pending   (n_pending)
    );

    // Present one reading and hold it until the block takes the beat.
    task automatic offer_reading(input logic rdy, input logic [RAW_W-1:0] raw);
        smp_bus.valid        <= 1'b1;
        smp_bus.sensor_ready <= rdy;
        smp_bus.raw_counts   <= raw;
        do @(posedge i_clk); while (smp_bus.ready !== 1'b1);
    endtask

    // Drop valid and hold off until every queued result has come back.
    task automatic drain_results();
        smp_bus.valid <= 1'b0;
        do @(negedge i_clk); while (n_pending != 0);
        @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= data;
        @(posedge i_clk);
    endtask

    // Write all registers (upper data bits random, they must be ignored) plus a stray index.
    // Call only with the block drained.
    task automatic apply_settings(input logic signed [OFFSET_W-1:0] offset,
                                  input logic [GAIN_W-1:0] gain,
                                  input logic [NEED_W-1:0] need);
        write_reg(CFG_ZERO_OFFSET, {7'($urandom), offset});
        write_reg(CFG_NO_REG, $urandom);
        write_reg(CFG_POUNDS_PER_CT, gain);
        write_reg(CFG_STABLE_NEEDED, {24'($urandom), need});
        cfg_we     <= 1'b0;
        set_offset = offset;
        set_need   = need;
    endtask

    // Stream runs of near-identical readings so equal-weight tracking gets deep,
    // broken up by not-ready beats, rail hits and stray readings (noise_pct percent).
    task automatic stream_readings(input int n_items, input int noise_pct);
        int               sent;
        int               run_left;
        int               pick;
        logic [RAW_W-1:0] base;
        sent     = 0;
        run_left = 0;
        base     = '0;
        while (sent < n_items) begin
            if (run_left == 0) begin
                // run length spans both sides of the threshold
                run_left = $urandom_range(1, int'(set_need) + 3);
                if ($urandom_range(0, 1) == 0) begin
                    base = RAW_W'($urandom);
                end else begin
                    // land near zero load so weights stay in a useful range
                    base = RAW_W'(int'(set_offset) + int'($urandom_range(0, 2000000)) - 20000);
                end
            end
            pick = $urandom_range(0, 99);
            if (pick < noise_pct / 2) begin
                offer_reading(1'b0, RAW_W'($urandom));
            end else if (pick < (noise_pct * 3) / 4) begin
                offer_reading(1'b1, ($urandom_range(0, 1) == 1) ? RAIL_HIGH : RAIL_LOW);
            end else if (pick < noise_pct) begin
                offer_reading(1'b1, RAW_W'($urandom));
            end else begin
                // small jitter mostly keeps the same rounded weight
                offer_reading(1'b1, base + RAW_W'($urandom_range(0, 6)) - RAW_W'(3));
                run_left--;
            end
            sent++;
            if (!calm && $urandom_range(0, 4) == 0) begin
                smp_bus.valid <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge i_clk);
            end
        end
    endtask

    // Result side: long ready stretches with short random stalls; no stalls when calm.
    initial begin
        res_bus.ready <= 1'b0;
        @(posedge i_clk);
        forever begin
            if (calm || $urandom_range(0, 3) != 0) begin
                res_bus.ready <= 1'b1;
                repeat ($urandom_range(1, 12)) @(posedge i_clk);
            end else begin
                res_bus.ready <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge i_clk);
            end
        end
    end

    initial begin
        calm                 = 1'b0;
        set_offset           = ZERO_OFFSET_RST;
        set_need             = NEED_RST;
        i_rst_n              <= 1'b0;
        cfg_we               <= 1'b0;
        cfg_idx              <= CFG_ZERO_OFFSET;
        cfg_data             <= '0;
        smp_bus.valid        <= 1'b0;
        smp_bus.sensor_ready <= 1'b0;
        smp_bus.raw_counts   <= '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed beats at reset settings (about 9170 counts per pound).
        // Not ready wins over everything, even a reading on a rail.
        offer_reading(1'b0, '0);
        offer_reading(1'b0, RAIL_HIGH);
        offer_reading(1'b0, RAIL_LOW);
        // Both rails saturate; one count inside them is a normal reading.
        offer_reading(1'b1, RAIL_HIGH);
        offer_reading(1'b1, RAIL_LOW);
        offer_reading(1'b1, RAW_W'(RAIL_HIGH - 1));
        offer_reading(1'b1, RAW_W'(RAIL_LOW + 1));
        // At and just above zero load: both weigh zero and extend the run.
        offer_reading(1'b1, RAW_W'(ZERO_OFFSET_RST));
        offer_reading(1'b1, RAW_W'(ZERO_OFFSET_RST + 1));
        // Near the half-pound rounding point.
        offer_reading(1'b1, RAW_W'(ZERO_OFFSET_RST + 4585));
        offer_reading(1'b1, RAW_W'(ZERO_OFFSET_RST + 4584));
        // Ten equal weights reach the reset threshold and ask for sleep.
        repeat (10) offer_reading(1'b1, RAW_W'(ZERO_OFFSET_RST + 45850));
        offer_reading(1'b1, RAW_W'(ZERO_OFFSET_RST + 45850));

        stream_readings(250, 14);

        // Pause the sender until every result is back before touching registers.
        drain_results();
        // Lowest offset, full gain: every valid reading saturates at 65535.
        apply_settings(25'h100_0000, 32'hFFFF_FFFF, 8'd1);
        stream_readings(150, 14);

        drain_results();
        // Highest offset: every valid reading weighs zero, so runs reach 255.
        apply_settings(25'sd16777215, $urandom, 8'd255);
        stream_readings(400, 0);

        drain_results();
        // Zero gain and zero threshold: sleep on every beat, valid or not.
        apply_settings(25'($urandom), 32'd0, 8'd0);
        stream_readings(100, 20);

        drain_results();
        apply_settings(25'(int'($urandom_range(0, 4000000)) - 2000000),
                       $urandom >> $urandom_range(4, 20), 8'($urandom_range(2, 20)));
        stream_readings(200, 14);

        drain_results();
        // Half a pound per count: odd differences land exactly on the rounding point.
        // No idling from here to the end.
        apply_settings(25'sd0, 32'h8000_0000, 8'd3);
        calm = 1'b1;
        stream_readings(150, 10);

        drain_results();
        repeat (END_HOLD) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest correct run.
    initial begin
        #4_000_000;
        $display("Mismatches found");
        $finish;
    end

endmodule

@@ filelist.f @@
src/lcwsd_pkg.sv
src/lcwsd_in_if.sv
src/lcwsd_out_if.sv
src/lcwsd_front.sv
src/lcwsd_queue.sv
src/lcwsd_back.sv
src/load_cell_weight_stability_detector.sv
src/lcwsd_checker.sv
tb/lcwsd_checker.sv
tb/tb_top.sv
